>>> sv/ssi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants for the segment / sphere crossing block: default formats
// and the configuration register indexes.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } cfg_idx_t;

endpackage
`default_nettype wire

>>> sv/segment_sphere_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle; a stall on m_tready freezes the whole pipeline.
// The depth is set by the square-root pipe (one root bit per stage, 2*COORD_WIDTH+3
// stages) and the rounding dividers (one quotient bit per stage, COORD_WIDTH stages).
// Reset (aresetn, synchronous, active low) clears all valid bits, the center to 0
// and the radius to 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
// segment_sphere_intersection
// Finds where a segment P1-P2 crosses a configured sphere, fully pipelined,
// with exact integer root tests and round-to-nearest crossing coordinates.
// ----------------------------------------------------------------------------
module segment_sphere_intersection #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ssi_pkg::FRAC_BITS_DEF,
    localparam int InTw  = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OutTw = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input items.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata: first_x, first_y, first_z, second_x, second_y, second_z (low to high)
    input  wire logic [InTw-1:0]                s_tdata,
    // Result items.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata: point_x, point_y, point_z (low to high), zero padded
    output logic [OutTw-1:0]                    m_tdata,
    // tuser: hit
    output logic [0:0]                          m_tuser,
    // Configuration writes.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ssi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COORD_WIDTH-1:0]         cfg_data
);
    import ssi_pkg::*;

    // Widths. d and e are differences of two coordinates; a, h and c are sums of
    // three products of those; the discriminant is h*h - a*c.
    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;          // d, e (signed)
    localparam int PW = 2 * W + 3;      // a, h, c (signed)
    localparam int MW = PW - 1;         // magnitudes of a, h, c and the numerator n
    localparam int LW = (MW + 1) / 2;   // low half for split multiplies
    localparam int UW = MW - LW;        // high half
    localparam int QW = 2 * MW + 2;     // discriminant (signed)
    localparam int SW = MW + 1;         // square root
    localparam int RW = SW + 2;         // square-root remainder
    localparam int CW = PW + 2;         // root tests (signed)
    localparam int NW = MW + W + 2;     // rounding dividend
    localparam int QB = W;              // quotient bits
    localparam logic [W-2:0] RadRst = ((W - 1) > FRAC_BITS) ?
                                      ((W - 1)'(1) << FRAC_BITS) : '0;

    typedef struct packed {
        logic [MW-1:0]          a;
        logic signed [PW-1:0]   h;
        logic signed [PW-1:0]   mh;     // -h
        logic signed [PW:0]     ah;     // a + h
        logic signed [PW:0]     mha;    // -h - a
        logic [2:0][DW-1:0]     d;
        logic [2:0][W-1:0]      p2;
    } ctx_t;

    typedef struct packed {
        logic                   hit;
        logic [MW-1:0]          a;
        logic [2:0]             dneg;
        logic [2:0][W-1:0]      p2;
    } octx_t;

    // ------------------------------------------------------------------
    // Configuration registers. The squared radius is refreshed every cycle;
    // the user must write only while the pipeline is empty; it is not enforced here.
    // ------------------------------------------------------------------
    logic signed [W-1:0]    ctr_reg [3];
    logic [W-2:0]           rad_reg;
    logic [2*W-3:0]         rr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg[0] <= '0;
            ctr_reg[1] <= '0;
            ctr_reg[2] <= '0;
            rad_reg    <= RadRst;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: ctr_reg[0] <= cfg_data;
                CFG_CENTER_Y: ctr_reg[1] <= cfg_data;
                CFG_CENTER_Z: ctr_reg[2] <= cfg_data;
                CFG_RADIUS:   rad_reg    <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rr_reg <= rad_reg * rad_reg;
    end

    // The whole pipeline moves together whenever the output register can take
    // a new item (it is empty or being drained this cycle).
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: d = P1 - P2, e = P2 - C.
    // ------------------------------------------------------------------
    logic                   s1_vld_reg;
    logic signed [DW-1:0]   s1_d_reg [3];
    logic signed [DW-1:0]   s1_e_reg [3];
    logic [W-1:0]           s1_p2_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                s1_d_reg[k]  <= DW'($signed(s_tdata[k*W +: W]))
                              - DW'($signed(s_tdata[(k+3)*W +: W]));
                s1_e_reg[k]  <= DW'($signed(s_tdata[(k+3)*W +: W])) - DW'(ctr_reg[k]);
                s1_p2_reg[k] <= s_tdata[(k+3)*W +: W];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the nine coordinate products.
    // ------------------------------------------------------------------
    logic                     s2_vld_reg;
    logic signed [2*DW-1:0]   s2_dd_reg [3];
    logic signed [2*DW-1:0]   s2_ed_reg [3];
    logic signed [2*DW-1:0]   s2_ee_reg [3];
    logic signed [DW-1:0]     s2_d_reg [3];
    logic [W-1:0]             s2_p2_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                s2_dd_reg[k] <= s1_d_reg[k] * s1_d_reg[k];
                s2_ed_reg[k] <= s1_e_reg[k] * s1_d_reg[k];
                s2_ee_reg[k] <= s1_e_reg[k] * s1_e_reg[k];
                s2_d_reg[k]  <= s1_d_reg[k];
                s2_p2_reg[k] <= s1_p2_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: a = d.d, h = e.d, c = e.e - R*R.
    // ------------------------------------------------------------------
    logic                   s3_vld_reg;
    logic [MW-1:0]          s3_a_reg;
    logic signed [PW-1:0]   s3_h_reg;
    logic signed [PW-1:0]   s3_c_reg;
    logic signed [DW-1:0]   s3_d_reg [3];
    logic [W-1:0]           s3_p2_reg [3];
    logic signed [PW-1:0]   s3_a_next;
    logic signed [PW-1:0]   s3_h_next;
    logic signed [PW-1:0]   s3_c_next;

    always_comb begin
        s3_a_next = PW'(s2_dd_reg[0]) + PW'(s2_dd_reg[1]) + PW'(s2_dd_reg[2]);
        s3_h_next = PW'(s2_ed_reg[0]) + PW'(s2_ed_reg[1]) + PW'(s2_ed_reg[2]);
        s3_c_next = PW'(s2_ee_reg[0]) + PW'(s2_ee_reg[1]) + PW'(s2_ee_reg[2])
                  - PW'($signed({1'b0, rr_reg}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_a_reg <= MW'(s3_a_next);
            s3_h_reg <= s3_h_next;
            s3_c_reg <= s3_c_next;
            for (int k = 0; k < 3; k++) begin
                s3_d_reg[k]  <= s2_d_reg[k];
                s3_p2_reg[k] <= s2_p2_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes for the wide products, and the sums the root
    // tests need later.
    // ------------------------------------------------------------------
    logic               s4_vld_reg;
    ctx_t               s4_ctx_reg;
    logic [MW-1:0]      s4_habs_reg;
    logic [MW-1:0]      s4_cabs_reg;
    logic               s4_cneg_reg;
    ctx_t               s4_ctx_next;
    logic signed [PW:0] s4_ax;

    always_comb begin
        s4_ax            = (PW + 1)'($signed({1'b0, s3_a_reg}));
        s4_ctx_next.a    = s3_a_reg;
        s4_ctx_next.h    = s3_h_reg;
        s4_ctx_next.mh   = -s3_h_reg;
        s4_ctx_next.ah   = s4_ax + (PW + 1)'(s3_h_reg);
        s4_ctx_next.mha  = -(PW + 1)'(s3_h_reg) - s4_ax;
        for (int k = 0; k < 3; k++) begin
            s4_ctx_next.d[k]  = s3_d_reg[k];
            s4_ctx_next.p2[k] = s3_p2_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_ctx_reg  <= s4_ctx_next;
            s4_habs_reg <= MW'(s3_h_reg[PW-1] ? -s3_h_reg : s3_h_reg);
            s4_cabs_reg <= MW'(s3_c_reg[PW-1] ? -s3_c_reg : s3_c_reg);
            s4_cneg_reg <= s3_c_reg[PW-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: half-width partial products of h*h and a*|c|.
    // ------------------------------------------------------------------
    logic                   s5_vld_reg;
    ctx_t                   s5_ctx_reg;
    logic                   s5_cneg_reg;
    logic [2*LW-1:0]        s5_hll_reg;
    logic [LW+UW-1:0]       s5_hlu_reg;
    logic [2*UW-1:0]        s5_huu_reg;
    logic [2*LW-1:0]        s5_all_reg;
    logic [LW+UW-1:0]       s5_alu_reg;
    logic [LW+UW-1:0]       s5_aul_reg;
    logic [2*UW-1:0]        s5_auu_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_ctx_reg  <= s4_ctx_reg;
            s5_cneg_reg <= s4_cneg_reg;
            s5_hll_reg  <= s4_habs_reg[LW-1:0] * s4_habs_reg[LW-1:0];
            s5_hlu_reg  <= s4_habs_reg[LW-1:0] * s4_habs_reg[MW-1:LW];
            s5_huu_reg  <= s4_habs_reg[MW-1:LW] * s4_habs_reg[MW-1:LW];
            s5_all_reg  <= s4_ctx_reg.a[LW-1:0] * s4_cabs_reg[LW-1:0];
            s5_alu_reg  <= s4_ctx_reg.a[LW-1:0] * s4_cabs_reg[MW-1:LW];
            s5_aul_reg  <= s4_ctx_reg.a[MW-1:LW] * s4_cabs_reg[LW-1:0];
            s5_auu_reg  <= s4_ctx_reg.a[MW-1:LW] * s4_cabs_reg[MW-1:LW];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: recombine h*h and a*|c|.
    // ------------------------------------------------------------------
    logic               s6_vld_reg;
    ctx_t               s6_ctx_reg;
    logic               s6_cneg_reg;
    logic [QW-1:0]      s6_hh_reg;
    logic [QW-1:0]      s6_ac_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_ctx_reg  <= s5_ctx_reg;
            s6_cneg_reg <= s5_cneg_reg;
            s6_hh_reg   <= QW'(s5_hll_reg) + (QW'(s5_hlu_reg) << (LW + 1))
                         + (QW'(s5_huu_reg) << (2 * LW));
            s6_ac_reg   <= QW'(s5_all_reg) + (QW'(s5_alu_reg) << LW)
                         + (QW'(s5_aul_reg) << LW) + (QW'(s5_auu_reg) << (2 * LW));
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: discriminant D = h*h - a*c, and the degenerate-segment flag.
    // ------------------------------------------------------------------
    logic               s7_vld_reg;
    ctx_t               s7_ctx_reg;
    logic [QW-1:0]      s7_disc_reg;
    logic               s7_azero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_ctx_reg   <= s6_ctx_reg;
            s7_disc_reg  <= s6_cneg_reg ? (s6_hh_reg + s6_ac_reg) : (s6_hh_reg - s6_ac_reg);
            s7_azero_reg <= (s6_ctx_reg.a == '0);
        end
    end

    // ------------------------------------------------------------------
    // Square-root pipe: one root bit per stage, floor root and remainder.
    // A negative discriminant is a miss and enters as zero.
    // ------------------------------------------------------------------
    logic               sq_vld_reg  [SW];
    logic               sq_miss_reg [SW];
    ctx_t               sq_ctx_reg  [SW];
    logic [QW-1:0]      sq_dsh_reg  [SW];
    logic [RW-1:0]      sq_rem_reg  [SW];
    logic [SW-1:0]      sq_root_reg [SW];

    for (genvar j = 0; j < SW; j++) begin : g_sqrt
        logic            vld_in;
        logic            miss_in;
        ctx_t            ctx_in;
        logic [QW-1:0]   dsh_in;
        logic [RW-1:0]   rem_in;
        logic [SW-1:0]   root_in;
        logic [RW+1:0]   rem2;
        logic [RW+1:0]   trial;
        logic            ge;

        if (j == 0) begin : g_first
            assign vld_in  = s7_vld_reg;
            assign miss_in = s7_azero_reg || s7_disc_reg[QW-1];
            assign ctx_in  = s7_ctx_reg;
            assign dsh_in  = s7_disc_reg[QW-1] ? '0 : s7_disc_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign vld_in  = sq_vld_reg[j-1];
            assign miss_in = sq_miss_reg[j-1];
            assign ctx_in  = sq_ctx_reg[j-1];
            assign dsh_in  = sq_dsh_reg[j-1];
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
        end

        assign rem2  = {rem_in, dsh_in[QW-1 -: 2]};
        assign trial = (RW + 2)'({root_in, 2'b01});
        assign ge    = (rem2 >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[j] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_miss_reg[j] <= miss_in;
                sq_ctx_reg[j]  <= ctx_in;
                sq_dsh_reg[j]  <= dsh_in << 2;
                sq_rem_reg[j]  <= RW'(ge ? (rem2 - trial) : rem2);
                sq_root_reg[j] <= {root_in[SW-2:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Root tests. With s = floor(sqrt(D)) and sc = ceil(sqrt(D)), the larger
    // root lies on the segment when s >= h and sc <= a + h; the smaller one
    // when sc <= -h and s >= -h - a. sc <= x is s < x when the remainder is
    // nonzero and s <= x otherwise.
    // ------------------------------------------------------------------
    logic               t1_vld_reg;
    logic               t1_miss_reg;
    ctx_t               t1_ctx_reg;
    logic [SW-1:0]      t1_s_reg;
    logic               t1_big_reg;
    logic               t1_small_reg;
    logic signed [CW-1:0] t1_s;
    logic               t1_rnz;
    logic               t1_big_next;
    logic               t1_small_next;

    always_comb begin
        t1_s   = CW'($signed({1'b0, sq_root_reg[SW-1]}));
        t1_rnz = |sq_rem_reg[SW-1];
        t1_big_next = (t1_s >= CW'(sq_ctx_reg[SW-1].h))
                   && (t1_rnz ? (t1_s <  CW'(sq_ctx_reg[SW-1].ah))
                              : (t1_s <= CW'(sq_ctx_reg[SW-1].ah)));
        t1_small_next = (t1_rnz ? (t1_s <  CW'(sq_ctx_reg[SW-1].mh))
                                : (t1_s <= CW'(sq_ctx_reg[SW-1].mh)))
                     && (t1_s >= CW'(sq_ctx_reg[SW-1].mha));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_miss_reg  <= sq_miss_reg[SW-1];
            t1_ctx_reg   <= sq_ctx_reg[SW-1];
            t1_s_reg     <= sq_root_reg[SW-1];
            t1_big_reg   <= t1_big_next;
            t1_small_reg <= t1_small_next;
        end
    end

    // Chosen numerator n (0 <= n <= a) and the segment direction magnitudes.
    logic               t2_vld_reg;
    octx_t              t2_ctx_reg;
    logic [MW-1:0]      t2_n_reg;
    logic [W-1:0]       t2_dabs_reg [3];
    logic signed [CW-1:0] t2_s;
    logic signed [CW-1:0] t2_n_next;
    octx_t              t2_ctx_next;
    logic signed [DW-1:0] t2_d [3];

    always_comb begin
        t2_s      = CW'($signed({1'b0, t1_s_reg}));
        t2_n_next = t1_big_reg ? (t2_s - CW'(t1_ctx_reg.h)) : (CW'(t1_ctx_reg.mh) - t2_s);
        t2_ctx_next.hit = !t1_miss_reg && (t1_big_reg || t1_small_reg);
        t2_ctx_next.a   = t1_ctx_reg.a;
        for (int k = 0; k < 3; k++) begin
            t2_d[k]              = $signed(t1_ctx_reg.d[k]);
            t2_ctx_next.dneg[k]  = t2_d[k][DW-1];
            t2_ctx_next.p2[k]    = t1_ctx_reg.p2[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_ctx_reg <= t2_ctx_next;
            t2_n_reg   <= MW'(t2_n_next);
            for (int k = 0; k < 3; k++) begin
                t2_dabs_reg[k] <= W'(t2_d[k][DW-1] ? -t2_d[k] : t2_d[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // |n*d| in two partial products, then the rounding dividend 2|n*d| + a.
    // ------------------------------------------------------------------
    logic               p1_vld_reg;
    octx_t              p1_ctx_reg;
    logic [LW+W-1:0]    p1_ppl_reg [3];
    logic [UW+W-1:0]    p1_ppu_reg [3];
    logic               p2_vld_reg;
    octx_t              p2_ctx_reg;
    logic [MW+W-1:0]    p2_mag_reg [3];
    logic               p3_vld_reg;
    octx_t              p3_ctx_reg;
    logic [NW-1:0]      p3_num_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_ctx_reg <= t2_ctx_reg;
            p2_ctx_reg <= p1_ctx_reg;
            p3_ctx_reg <= p2_ctx_reg;
            for (int k = 0; k < 3; k++) begin
                p1_ppl_reg[k] <= t2_n_reg[LW-1:0] * t2_dabs_reg[k];
                p1_ppu_reg[k] <= t2_n_reg[MW-1:LW] * t2_dabs_reg[k];
                p2_mag_reg[k] <= (MW + W)'(p1_ppl_reg[k])
                               + ((MW + W)'(p1_ppu_reg[k]) << LW);
                p3_num_reg[k] <= NW'({p2_mag_reg[k], 1'b0}) + NW'(p2_ctx_reg.a);
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring dividers by 2a, one quotient bit per stage, most significant
    // first: q = floor((2|n*d| + a) / 2a), i.e. |n*d|/a rounded half up.
    // ------------------------------------------------------------------
    logic               dv_vld_reg [QB];
    octx_t              dv_ctx_reg [QB];
    logic [NW-1:0]      dv_rem_reg [QB][3];
    logic [QB-1:0]      dv_q_reg   [QB][3];

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic            vld_in;
        octx_t           ctx_in;
        logic [NW-1:0]   rem_in [3];
        logic [QB-1:0]   q_in   [3];
        logic [NW-1:0]   sub;

        if (j == 0) begin : g_first
            assign vld_in = p3_vld_reg;
            assign ctx_in = p3_ctx_reg;
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign rem_in[k] = p3_num_reg[k];
                assign q_in[k]   = '0;
            end
        end else begin : g_next
            assign vld_in = dv_vld_reg[j-1];
            assign ctx_in = dv_ctx_reg[j-1];
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign rem_in[k] = dv_rem_reg[j-1][k];
                assign q_in[k]   = dv_q_reg[j-1][k];
            end
        end

        assign sub = NW'({ctx_in.a, 1'b0}) << (QB - 1 - j);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_ctx_reg[j] <= ctx_in;
                for (int k = 0; k < 3; k++) begin
                    if (rem_in[k] >= sub) begin
                        dv_rem_reg[j][k] <= rem_in[k] - sub;
                        dv_q_reg[j][k]   <= {q_in[k][QB-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[j][k] <= rem_in[k];
                        dv_q_reg[j][k]   <= {q_in[k][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: point = P2 +/- q, all zero on a miss.
    // ------------------------------------------------------------------
    octx_t              fin_ctx;
    logic [W-1:0]       fin_pt [3];
    logic               m_hit_reg;
    logic [W-1:0]       m_pt_reg [3];

    always_comb begin
        fin_ctx = dv_ctx_reg[QB-1];
        for (int k = 0; k < 3; k++) begin
            fin_pt[k] = fin_ctx.dneg[k] ? (fin_ctx.p2[k] - dv_q_reg[QB-1][k])
                                        : (fin_ctx.p2[k] + dv_q_reg[QB-1][k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg <= fin_ctx.hit;
            for (int k = 0; k < 3; k++) begin
                m_pt_reg[k] <= fin_ctx.hit ? fin_pt[k] : '0;
            end
        end
    end

    // Valid bits of the fixed stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            s5_vld_reg   <= 1'b0;
            s6_vld_reg   <= 1'b0;
            s7_vld_reg   <= 1'b0;
            t1_vld_reg   <= 1'b0;
            t2_vld_reg   <= 1'b0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p3_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg   <= s_tvalid;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            s4_vld_reg   <= s3_vld_reg;
            s5_vld_reg   <= s4_vld_reg;
            s6_vld_reg   <= s5_vld_reg;
            s7_vld_reg   <= s6_vld_reg;
            t1_vld_reg   <= sq_vld_reg[SW-1];
            t2_vld_reg   <= t1_vld_reg;
            p1_vld_reg   <= t2_vld_reg;
            p2_vld_reg   <= p1_vld_reg;
            p3_vld_reg   <= p2_vld_reg;
            m_tvalid_reg <= dv_vld_reg[QB-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = OutTw'({m_pt_reg[2], m_pt_reg[1], m_pt_reg[0]});

`ifndef SYNTHESIS
    // An accepted item always shows up in the first stage.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> s1_vld_reg)
        else $error("accepted item did not enter the pipeline");

    // The square-root remainder never exceeds twice the root.
    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_vld_reg[SW-1] |-> (sq_rem_reg[SW-1] <= RW'({sq_root_reg[SW-1], 1'b0})))
        else $error("square-root remainder out of range");

    // A hit is never reported for a degenerate segment.
    a_hit_nonzero_a: assert property (@(posedge aclk) disable iff (!aresetn)
        t2_vld_reg && t2_ctx_reg.hit |-> (t2_ctx_reg.a != '0))
        else $error("hit reported with zero segment length");

    // A miss leaves all point fields at zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("miss with nonzero point");
`endif

endmodule
`default_nettype wire
